### hdl/gba_pkg.sv
package gba_pkg;

    typedef enum logic [1:0] {
        MODE_MIN = 2'd0,
        MODE_MAX = 2'd1,
        MODE_SUM = 2'd2,
        MODE_AVG = 2'd3
    } agg_mode_t;

    localparam logic CMD_ACCUM  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // One table entry as it sits in a cell.
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] agg;
        logic [31:0] count;
    } slot_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic        acc;
        logic        ins;
        logic        shift_out;
        logic [31:0] key;
        logic [31:0] value;
        agg_mode_t   mode;
    } cell_ctrl_t;

endpackage

### hdl/gba_if.sv
interface gba_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] group_key;
    logic [31:0] agg_value;

    modport source (output valid, cmd, group_key, agg_value, input ready);
    modport sink (input valid, cmd, group_key, agg_value, output ready);
endinterface

interface gba_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic        last;
    logic        empty_res;
    logic        overflow;

    modport source (output valid, out_key, out_value, last, empty_res, overflow,
                    input ready);
    modport sink (input valid, out_key, out_value, last, empty_res, overflow,
                  output ready);
endinterface

### hdl/gba_cell.sv
module gba_cell
    import gba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  slot_t      left,
    input  logic       left_gt,
    input  slot_t      right,
    output slot_t      slot,
    output logic       gt,
    output logic       hit
);

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [31:0] agg_reg;
    logic [31:0] count_reg;
    slot_t       cur;
    slot_t       slot_next;
    logic        mine_gt;
    logic        cnt_full;

    assign cur      = {valid_reg, key_reg, agg_reg, count_reg};
    assign mine_gt  = cur.valid && ($signed(cur.key) > $signed(ctrl.key));
    // Only an accepted accumulate transaction may match and fold.
    assign hit      = ctrl.acc && cur.valid && (cur.key == ctrl.key);
    assign gt       = mine_gt || !cur.valid;
    assign cnt_full = &cur.count;

    always_comb
    begin
        slot_next = cur;
        if (ctrl.shift_out)
        begin
            slot_next = right;
        end
        else if (hit)
        begin
            if (!cnt_full) slot_next.count = cur.count + 32'd1;
            case (ctrl.mode)
                MODE_MIN: if ($signed(ctrl.value) < $signed(cur.agg))
                              slot_next.agg = ctrl.value;
                MODE_MAX: if ($signed(ctrl.value) > $signed(cur.agg))
                              slot_next.agg = ctrl.value;
                default:  slot_next.agg = cur.agg + ctrl.value;
            endcase
        end
        else if (ctrl.ins && gt)
        begin
            // The new key lands here when the left neighbor is below it;
            // otherwise the chain shifts right by one from the landing cell.
            if (!left_gt)
            begin
                slot_next.valid = 1'b1;
                slot_next.key   = ctrl.key;
                slot_next.agg   = ctrl.value;
                slot_next.count = 32'd1;
            end
            else
            begin
                slot_next = left;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else        valid_reg <= slot_next.valid;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= slot_next.key;
        agg_reg   <= slot_next.agg;
        count_reg <= slot_next.count;
    end

    assign slot = cur;

endmodule

### hdl/gba_div.sv
module gba_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] sum,
    input  logic [31:0] count,
    output logic        busy,
    output logic [31:0] quot
);

    logic [5:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic [32:0] trial;

    assign busy  = cnt_reg != 6'd0;
    assign trial = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};
    assign quot  = neg_reg ? (32'd0 - q_reg) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      cnt_reg <= 6'd0;
        else if (start)  cnt_reg <= 6'd32;
        else if (busy)   cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            neg_reg <= sum[31];
            q_reg   <= sum[31] ? (32'd0 - sum) : sum;
            r_reg   <= 33'd0;
            d_reg   <= count;
        end else if (busy) begin
            if (!trial[32]) begin
                r_reg <= trial;
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= {r_reg[31:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

endmodule

### hdl/group_by_aggregator_unit.sv
// Accumulate rows are taken back to back; ready is high between finishes.
// Finish: min, max and sum results leave one per cycle while the output is
// ready; average runs each group through the 32-step serial divider. Ready
// returns once the output is empty and the state is back in accumulate.
// Reset clears all valid bits, the sticky drop flag (not the overflow output)
// and the mode register at once; no clear pass.
module group_by_aggregator_unit
    import gba_pkg::*;
#(
    parameter int MAX_GROUPS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    gba_in_if.sink     in_ch,
    gba_out_if.source  out_ch
);

    typedef enum logic [3:0] {
        ST_ACC  = 4'b0001,
        ST_SEL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    agg_mode_t  mode_reg;
    logic       drop_reg, drop_next;
    cell_ctrl_t ctrl;

    slot_t slots [MAX_GROUPS];
    logic  gts   [MAX_GROUPS];
    logic  hits  [MAX_GROUPS];
    slot_t empty_slot;

    logic any_hit, full, accept, accum, fin;
    logic [31:0] okey_reg, oval_reg;
    logic        olast_reg, oempty_reg, oovf_reg, ovalid_reg, ovalid_next;
    logic        div_start, div_busy;
    logic [31:0] div_quot;

    assign empty_slot = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      mode_reg <= MODE_MIN;
        else if (cfg_we) mode_reg <= agg_mode_t'(cfg_wdata);
    end

    always_comb
    begin
        any_hit = 1'b0;
        for (int i = 0; i < MAX_GROUPS; i++) any_hit = any_hit | hits[i];
    end

    assign full   = slots[MAX_GROUPS-1].valid;
    assign accept = in_ch.valid && in_ch.ready;
    assign accum  = accept && (in_ch.cmd == CMD_ACCUM);
    assign fin    = accept && (in_ch.cmd == CMD_FINISH);
    assign in_ch.ready = (state_reg == ST_ACC);

    // The head cell is taken into the output register in the cycle it shifts.
    logic take;
    assign take = (state_reg == ST_SEL) && (!ovalid_reg || out_ch.ready)
                  && slots[0].valid && (mode_reg != MODE_AVG);

    always_comb
    begin
        ctrl.acc       = accum;
        ctrl.ins       = accum && !any_hit && !full;
        ctrl.shift_out = take || div_start;
        ctrl.key       = in_ch.group_key;
        ctrl.value     = in_ch.agg_value;
        ctrl.mode      = mode_reg;
        if (!accum)
        begin
            ctrl.ins = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_GROUPS; g++)
        begin : g_cell
            gba_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .left    ((g == 0) ? empty_slot : slots[(g == 0) ? 0 : g-1]),
                .left_gt ((g == 0) ? 1'b0 : gts[(g == 0) ? 0 : g-1]),
                .right   ((g == MAX_GROUPS-1) ? empty_slot
                                              : slots[(g == MAX_GROUPS-1) ? g : g+1]),
                .slot    (slots[g]),
                .gt      (gts[g]),
                .hit     (hits[g])
            );
        end
    endgenerate

    assign div_start = (state_reg == ST_SEL) && slots[0].valid && (mode_reg == MODE_AVG)
                       && (!ovalid_reg || out_ch.ready);

    gba_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (slots[0].agg),
        .count (slots[0].count),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    logic        pend_last_reg;
    logic [31:0] pend_key_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: if (fin) state_next = ST_SEL;
            ST_SEL:
            begin
                if (!slots[0].valid && !ovalid_reg) state_next = ST_ACC;
                else if (div_start)                 state_next = ST_DIV;
            end
            ST_DIV: if (!div_busy) state_next = ST_OUT;
            ST_OUT: state_next = ST_SEL;
            default: state_next = ST_ACC;
        endcase
    end

    // Output valid and the sticky drop flag. The flag leaves the table once
    // the run is fully handed off, or at once for an empty finish.
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ch.ready) ovalid_next = 1'b0;
        if ((fin && !slots[0].valid) || take || (state_reg == ST_OUT))
            ovalid_next = 1'b1;
        drop_next = drop_reg;
        if (accum && !any_hit && full) drop_next = 1'b1;
        if ((state_reg == ST_SEL && state_next == ST_ACC) || (fin && !slots[0].valid))
            drop_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_ACC;
            drop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            drop_reg   <= drop_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            oovf_reg <= drop_reg;
            if (!slots[0].valid)
            begin
                okey_reg   <= '0;
                oval_reg   <= '0;
                olast_reg  <= 1'b1;
                oempty_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            okey_reg   <= slots[0].key;
            oval_reg   <= slots[0].agg;
            olast_reg  <= !slots[1].valid;
            oempty_reg <= 1'b0;
        end
        else if (div_start)
        begin
            pend_key_reg  <= slots[0].key;
            pend_last_reg <= !slots[1].valid;
        end
        else if (state_reg == ST_OUT)
        begin
            okey_reg   <= pend_key_reg;
            oval_reg   <= div_quot;
            olast_reg  <= pend_last_reg;
            oempty_reg <= 1'b0;
        end
    end

    assign out_ch.valid     = ovalid_reg;
    assign out_ch.out_key   = okey_reg;
    assign out_ch.out_value = oval_reg;
    assign out_ch.last      = olast_reg;
    assign out_ch.empty_res = oempty_reg;
    assign out_ch.overflow  = oovf_reg;

    // Inserting into a full table must never happen.
    a_no_full_ins: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.ins && full)) else $error("insert into full chain");

    // Input is never taken while results drain.
    a_no_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACC) |-> !in_ch.ready) else $error("accept while draining");

    // A result held under back-pressure stays valid and keeps its key.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ch.ready) |=> (ovalid_reg && $stable(okey_reg)))
        else $error("result changed under stall");

endmodule
